>>> hw/rtl/pwerd_pkg.sv
// Shared types and constants for the per-id windowed event rate detector.
`default_nettype none
package pwerd_pkg;
    localparam int PID_W = 22;
    localparam int CNT_W = 11;
    localparam int GEN_W = 4;
    localparam int TIME_W = 16;
    localparam int AGE_W = 15;
    localparam int THR_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_EVENT = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_CHECK = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_FLAG       = 2'd0,
        KIND_TABLE_FULL = 2'd1,
        KIND_FIFO_FULL  = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] REG_READ_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE   = 2'd2;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [PID_W-1:0] id;
        logic             last;
    } t_result;
endpackage
`default_nettype wire

>>> hw/rtl/pwerd_fifo.sv
// Event record memory with registered read at the head.
`default_nettype none
module pwerd_fifo #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 37
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/per_id_windowed_event_rate_detector.sv
// Per-id windowed event rate detector: top level with table, sequencer and output.
// Usage: one input channel (i_valid/o_ready) takes a func code with a process id
// and an event mask; one output channel (o_valid/i_ready) gives results, the
// final result of an item marked by o_last. Registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it. Each item is walked by
// one sequencer that visits one table slot per cycle while a new result fits, and
// reads FIFO records one at a time. A file event clears its set mask bits one by
// one, searching the table for the id and, for a new id, for a free slot. A tick
// reads each head record through the registered memory port and retires it while
// it is at least the maximum age old. A check scans up to TABLE_ENTRIES slots and
// stops after 16 results.
// o_ready is low while an item is in work. The newest result waits in a pending
// register until it is known whether it is the last one of its item, then moves
// to the output register, where it waits until transferred; when both are full
// the sequencer holds, so a stalled receiver adds its stall to the item's time.
// Reset clears the table, the FIFO pointers and time, and sets the registers to
// their defaults; no clearing pass is needed since FIFO records are read only after written.
`default_nettype none
module per_id_windowed_event_rate_detector #(
    parameter int TABLE_ENTRIES = 16,
    parameter int FIFO_DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [1:0]                       i_func,
    input  wire logic [pwerd_pkg::PID_W-1:0]      i_proc_id,
    input  wire logic                             i_ev_access,
    input  wire logic                             i_ev_access_perm,
    input  wire logic                             i_ev_modify,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [1:0]                            o_kind,
    output logic [pwerd_pkg::PID_W-1:0]           o_flagged_id,
    output logic                                  o_last,
    input  wire logic                             i_cfg_we,
    input  wire logic [pwerd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pwerd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int RSW = 6;
    localparam int RECW = pwerd_pkg::TIME_W + RSW + pwerd_pkg::GEN_W + 1;
    localparam logic [FW-1:0] FIFO_FULL = FW'(FIFO_DEPTH);
    localparam logic [SCW-1:0] SLOT_END = SCW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_BIT, S_SEARCH, S_FREE, S_TICK_RD, S_TICK_CHK, S_CHECK, S_DONE
    } t_state;

    t_state r_state;
    logic [pwerd_pkg::THR_W-1:0] r_read_thr, r_write_thr;
    logic [pwerd_pkg::AGE_W-1:0] r_max_age;
    logic [TABLE_ENTRIES-1:0] r_slot_valid;
    logic [pwerd_pkg::PID_W-1:0] r_slot_pid [TABLE_ENTRIES];
    logic [pwerd_pkg::CNT_W-1:0] r_rd_cnt [TABLE_ENTRIES];
    logic [pwerd_pkg::CNT_W-1:0] r_wr_cnt [TABLE_ENTRIES];
    logic [pwerd_pkg::GEN_W-1:0] r_gen [TABLE_ENTRIES];
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [pwerd_pkg::TIME_W-1:0] r_now;
    logic [pwerd_pkg::PID_W-1:0] r_pid;
    logic [2:0] r_bits;
    logic [SCW-1:0] r_idx;
    logic [4:0] r_nres;
    pwerd_pkg::t_result r_pend;
    pwerd_pkg::t_result r_out;

    logic fifo_we;
    logic [AW-1:0] fifo_waddr;
    logic [31:0] wsum;
    logic [RECW-1:0] fifo_wdata, fifo_rdata;

    pwerd_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(RECW)) u_fifo (
        .i_clk  (i_clk),
        .i_we   (fifo_we),
        .i_waddr(fifo_waddr),
        .i_wdata(fifo_wdata),
        .i_raddr(r_head),
        .o_rdata(fifo_rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out.valid;
    assign o_kind = r_out.kind;
    assign o_flagged_id = r_out.id;
    assign o_last = r_out.last;

    // Lowest pending mask bit in order access, access-perm, modify.
    logic [1:0] cur_b;
    always_comb begin
        if (r_bits[0]) begin
            cur_b = 2'd0;
        end else if (r_bits[1]) begin
            cur_b = 2'd1;
        end else begin
            cur_b = 2'd2;
        end
    end

    logic out_free, out_xfer, res_free;
    assign out_xfer = r_out.valid && i_ready;
    assign out_free = !r_out.valid || i_ready;
    // A new result fits when the pending one can move on to the output register.
    assign res_free = !r_pend.valid || out_free;
    logic [SW-1:0] si;
    assign si = r_idx[SW-1:0];

    logic [pwerd_pkg::TIME_W-1:0] rec_time, age;
    logic [RSW-1:0] rec_slot;
    logic [pwerd_pkg::GEN_W-1:0] rec_gen;
    logic rec_wr;
    assign {rec_time, rec_slot, rec_gen, rec_wr} = fifo_rdata;
    assign age = r_now - rec_time;

    logic hit;
    assign hit = r_slot_valid[si] && r_slot_pid[si] == r_pid;
    logic flag;
    assign flag = r_slot_valid[si]
        && 16'(r_rd_cnt[si]) >= r_read_thr && 16'(r_wr_cnt[si]) >= r_write_thr;

    always_comb begin
        wsum = 32'(r_head) + 32'(r_fill);
        fifo_we = 1'b0;
        fifo_waddr = (wsum >= FIFO_DEPTH) ? AW'(wsum - FIFO_DEPTH) : AW'(wsum);
        fifo_wdata = {r_now, RSW'(si), r_gen[si], (cur_b == 2'd2)};
        if (r_state == S_BIT && res_free && r_bits != 3'b0 && r_fill != FIFO_FULL
            && hit) begin
            fifo_we = 1'b1;
        end
    end

    // Result produced by the sequencer in this cycle.
    logic gen_res;
    pwerd_pkg::t_kind gen_kind;
    logic [pwerd_pkg::PID_W-1:0] gen_id;
    logic flush;
    always_comb begin
        gen_res = 1'b0;
        gen_kind = pwerd_pkg::KIND_FLAG;
        gen_id = r_pid;
        unique case (r_state)
            S_BIT: begin
                if (r_bits != 3'b0 && r_fill == FIFO_FULL) begin
                    gen_res = res_free;
                    gen_kind = pwerd_pkg::KIND_FIFO_FULL;
                end
            end
            S_FREE: begin
                if (r_slot_valid[si] && r_idx + 1'b1 == SLOT_END) begin
                    gen_res = res_free;
                    gen_kind = pwerd_pkg::KIND_TABLE_FULL;
                end
            end
            S_CHECK: begin
                if (r_idx != SLOT_END && r_nres != 5'd16 && flag) begin
                    gen_res = res_free;
                    gen_id = r_slot_pid[si];
                end
            end
            default: ;
        endcase
    end
    assign flush = (r_state == S_DONE) && r_pend.valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_read_thr <= 16'd300;
            r_write_thr <= 16'd300;
            r_max_age <= 15'd150;
            r_slot_valid <= '0;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_rd_cnt[k] <= '0;
                r_wr_cnt[k] <= '0;
                r_gen[k] <= '0;
            end
            r_head <= '0;
            r_fill <= '0;
            r_now <= '0;
            r_out.valid <= 1'b0;
            r_pend.valid <= 1'b0;
            r_idx <= '0;
            r_nres <= '0;
            r_bits <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pwerd_pkg::REG_READ_THR:  r_read_thr <= i_cfg_data;
                    pwerd_pkg::REG_WRITE_THR: r_write_thr <= i_cfg_data;
                    pwerd_pkg::REG_MAX_AGE:   r_max_age <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (gen_res) begin
                if (r_pend.valid) begin
                    r_out <= '{1'b1, r_pend.kind, r_pend.id, 1'b0};
                end else if (out_xfer) begin
                    r_out.valid <= 1'b0;
                end
                r_pend <= '{1'b1, gen_kind, gen_id, 1'b0};
            end else if (flush) begin
                r_out <= '{1'b1, r_pend.kind, r_pend.id, 1'b1};
                r_pend.valid <= 1'b0;
            end else if (out_xfer) begin
                r_out.valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pid <= i_proc_id;
                        r_bits <= {i_ev_modify, i_ev_access_perm, i_ev_access};
                        r_idx <= '0;
                        r_nres <= '0;
                        case (i_func)
                            pwerd_pkg::FUNC_EVENT: r_state <= S_BIT;
                            pwerd_pkg::FUNC_TICK: begin
                                r_now <= r_now + 1'b1;
                                r_state <= S_TICK_RD;
                            end
                            pwerd_pkg::FUNC_CHECK: r_state <= S_CHECK;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // Scan slots for the id; r_idx walks the table one slot a cycle while a new result fits.
                S_BIT: begin
                    if (r_bits == 3'b0) begin
                        r_state <= S_DONE;
                    end else if (res_free) begin
                        if (r_fill == FIFO_FULL) begin
                            r_bits[cur_b] <= 1'b0;
                            r_idx <= '0;
                        end else if (hit) begin
                            if (cur_b == 2'd2) begin
                                if (r_wr_cnt[si] != pwerd_pkg::CNT_MAX)
                                    r_wr_cnt[si] <= r_wr_cnt[si] + 1'b1;
                            end else if (r_rd_cnt[si] != pwerd_pkg::CNT_MAX) begin
                                r_rd_cnt[si] <= r_rd_cnt[si] + 1'b1;
                            end
                            r_fill <= r_fill + 1'b1;
                            r_bits[cur_b] <= 1'b0;
                        end else if (r_idx + 1'b1 == SLOT_END) begin
                            r_idx <= '0;
                            r_state <= S_FREE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FREE: begin
                    if (!r_slot_valid[si]) begin
                        r_slot_valid[si] <= 1'b1;
                        r_slot_pid[si] <= r_pid;
                        r_rd_cnt[si] <= '0;
                        r_wr_cnt[si] <= '0;
                        r_state <= S_BIT;
                    end else if (r_idx + 1'b1 == SLOT_END) begin
                        if (res_free) begin
                            r_bits <= '0;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // Memory read of the head record lands next cycle.
                S_TICK_RD: begin
                    r_state <= (r_fill == '0) ? S_DONE : S_TICK_CHK;
                end
                S_TICK_CHK: begin
                    if (age < 16'(r_max_age)) begin
                        r_state <= S_DONE;
                    end else begin
                        if (32'(rec_slot) < TABLE_ENTRIES
                            && r_slot_valid[SW'(rec_slot)]
                            && r_gen[SW'(rec_slot)] == rec_gen) begin
                            if (rec_wr) begin
                                if (r_wr_cnt[SW'(rec_slot)] != '0)
                                    r_wr_cnt[SW'(rec_slot)] <= r_wr_cnt[SW'(rec_slot)] - 1'b1;
                            end else if (r_rd_cnt[SW'(rec_slot)] != '0) begin
                                r_rd_cnt[SW'(rec_slot)] <= r_rd_cnt[SW'(rec_slot)] - 1'b1;
                            end
                        end
                        if (32'(r_head) == FIFO_DEPTH - 1) begin
                            r_head <= '0;
                        end else begin
                            r_head <= r_head + 1'b1;
                        end
                        r_fill <= r_fill - 1'b1;
                        r_state <= S_TICK_RD;
                    end
                end
                S_CHECK: begin
                    if (r_idx == SLOT_END || r_nres == 5'd16) begin
                        r_state <= S_DONE;
                    end else if (res_free) begin
                        if (flag) begin
                            r_nres <= r_nres + 1'b1;
                            r_slot_valid[si] <= 1'b0;
                            r_rd_cnt[si] <= '0;
                            r_wr_cnt[si] <= '0;
                            r_gen[si] <= r_gen[si] + 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // The pending result is the item's last; it leaves once the output is free.
                S_DONE: begin
                    if (!r_pend.valid || out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_fill_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_fill <= FIFO_FULL;
    endproperty
    assert property (p_fill_bound) else $error("fifo fill beyond depth");

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != S_IDLE) |-> !o_ready;
    endproperty
    assert property (p_no_accept_busy) else $error("ready while busy");

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && !i_ready) |=> (o_valid && $stable(o_flagged_id));
    endproperty
    assert property (p_out_hold) else $error("result dropped");
endmodule
`default_nettype wire
